[hw/rtl/bfm_pkg.sv]
// shared constants, types and splitmix64 hash constants for the bloom filter block
package bfm_pkg;

  localparam int unsigned FILTER_BITS_DEF = 16384;
  localparam int unsigned NH_W = 5;
  localparam int unsigned BC_W = 15;
  localparam int unsigned OP_W = 2;
  localparam int unsigned KEY_W = 64;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [0:0] CFG_NUM_HASHES = 1'b0;
  localparam logic [0:0] CFG_BIT_COUNT  = 1'b1;

  localparam logic [NH_W-1:0] NH_RESET = 5'd7;
  localparam logic [BC_W-1:0] BC_RESET = 15'd16384;

  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;
  localparam logic [63:0] STRIDE = 64'h00000000deadbeef;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture key, reset probe offset
    logic hash_go;   // start hashing the current probe
    logic next;      // advance probe offset
    logic set_bit;   // write 1 at probe index
    logic rd_bit;    // read bit at probe index
    logic clr_go;    // start clearing sweep
    logic clr_step;  // clear one bit
  } bfm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic idx_valid; // probe index ready
    logic bit_val;   // registered read data
    logic clr_done;  // sweep at last entry
  } bfm_sts_t;

endpackage

[hw/rtl/bfm_mul64.sv]
// 64x64 low-half multiplier summing three 32x32 partial products in turn
module bfm_mul64
  import bfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [31:0] ma, mb;
  logic [63:0] pp;
  logic        done_r, done_nxt;

  always_comb begin
    ma = a_r[31:0];
    mb = b_r[31:0];
    case (cnt_r)
      3'd0: begin ma = a_r[31:0];  mb = b_r[31:0];  end
      3'd1: begin ma = a_r[63:32]; mb = b_r[31:0];  end
      3'd2: begin ma = a_r[31:0];  mb = b_r[63:32]; end
      default: begin ma = a_r[31:0]; mb = b_r[31:0]; end
    endcase
  end

  assign pp = 64'(ma) * 64'(mb);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == 3'd0) acc_nxt = pp;
      else acc_nxt = acc_r + {pp[31:0], 32'd0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    if (go) begin
      a_r <= a;
      b_r <= b;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

[hw/rtl/bfm_mod.sv]
// bit-serial 64-bit remainder by a modulus, one quotient bit per cycle
module bfm_mod
  import bfm_pkg::*;
#(
  parameter int unsigned MW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [63:0]   num,
  input  logic [MW-1:0] den,
  output logic          done,
  output logic [MW-1:0] rem
);

  logic [63:0]   n_r;
  logic [MW:0]   r_r, r_nxt, trial;
  logic [6:0]    cnt_r;
  logic          busy_r, done_r;

  assign trial = {r_r[MW-1:0], n_r[63]};
  assign r_nxt = (trial >= {1'b0, den}) ? trial - {1'b0, den} : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (go) begin
      n_r <= num;
      r_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[62:0], 1'b0};
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r[MW-1:0];

endmodule

[hw/rtl/bfm_datapath.sv]
// key register, splitmix64 hash sequence, modulo unit and filter bit memory
module bfm_datapath
  import bfm_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bfm_cmd_t         cmd,
  input  logic [KEY_W-1:0] key,
  input  logic [BC_W-1:0]  bit_count,
  output bfm_sts_t         sts
);

  localparam int unsigned AW = $clog2(FILTER_BITS);
  localparam int unsigned MW = AW + 1;

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_M1   = 3'd1;
  localparam logic [2:0] H_M2   = 3'd2;
  localparam logic [2:0] H_MOD  = 3'd3;
  localparam logic [2:0] H_DONE = 3'd4;

  logic [63:0] key_r, off_r, v_r;
  logic [2:0]  hs_r;
  logic        mul_go, mul_done, mod_go, mod_done;
  logic [63:0] mul_a, mul_b, mul_p, v1;
  logic [MW-1:0] den, rem;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] clr_r;
  logic          bit_r;
  logic          mem [FILTER_BITS];
  logic [MW-1:0] m_eff;

  // effective modulus: zero becomes one, above capacity saturates
  always_comb begin
    if (bit_count == '0) m_eff = MW'(1);
    else if (32'(bit_count) > FILTER_BITS) m_eff = MW'(FILTER_BITS);
    else m_eff = MW'(bit_count);
  end
  assign den = m_eff;

  assign v1 = key_r + off_r + GOLDEN;

  always_comb begin
    mul_go = 1'b0;
    mul_a  = v_r ^ (v_r >> 30);
    mul_b  = MIX1;
    mod_go = 1'b0;
    case (hs_r)
      H_IDLE: begin
        mul_go = cmd.hash_go;
        mul_a  = v1 ^ (v1 >> 30);
        mul_b  = MIX1;
      end
      H_M1: begin
        mul_go = mul_done;
        mul_a  = mul_p ^ (mul_p >> 27);
        mul_b  = MIX2;
      end
      H_M2: mod_go = mul_done;
      default: ;
    endcase
  end

  bfm_mul64 u_mul (
    .clk (clk), .rst_n (rst_n), .go (mul_go), .a (mul_a), .b (mul_b),
    .done (mul_done), .p (mul_p)
  );

  bfm_mod #(.MW(MW)) u_mod (
    .clk (clk), .rst_n (rst_n), .go (mod_go), .num (mul_p ^ (mul_p >> 31)),
    .den (den), .done (mod_done), .rem (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r <= H_IDLE;
    end else begin
      case (hs_r)
        H_IDLE: if (cmd.hash_go) hs_r <= H_M1;
        H_M1:   if (mul_done) hs_r <= H_M2;
        H_M2:   if (mul_done) hs_r <= H_MOD;
        H_MOD:  if (mod_done) hs_r <= H_DONE;
        H_DONE: hs_r <= H_IDLE;
        default: hs_r <= H_IDLE;
      endcase
    end
    if (mod_done) idx_r <= rem[AW-1:0];
    if (cmd.load) begin
      key_r <= key;
      off_r <= '0;
    end else if (cmd.next) begin
      off_r <= off_r + STRIDE;
    end
    v_r <= v1;
  end

  // single-port bit store
  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_r] <= 1'b0;
    else if (cmd.set_bit) mem[idx_r] <= 1'b1;
    if (cmd.rd_bit) bit_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_go) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + AW'(1);
  end

  assign sts.idx_valid = (hs_r == H_DONE);
  assign sts.bit_val   = bit_r;
  assign sts.clr_done  = (clr_r == AW'(FILTER_BITS - 1));

endmodule

[hw/rtl/bfm_ctrl.sv]
// controller sequencing probes, bit accesses and the clearing sweep
module bfm_ctrl
  import bfm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] op,
  input  logic [NH_W-1:0] num_hashes,
  input  bfm_sts_t        sts,
  output bfm_cmd_t        cmd,
  output logic            busy,
  output logic            out_strobe,
  output logic            out_maybe_present
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_NEXT  = 3'd5;

  logic [2:0]      st_r, st_nxt;
  logic [NH_W-1:0] cnt_r, cnt_nxt, nh_r, nh_nxt;
  logic            chk_r, chk_nxt;
  logic            strb_r, strb_nxt, pres_r, pres_nxt;
  logic            accept;

  assign accept = start && !busy;
  assign busy   = (st_r != S_IDLE);

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    nh_nxt   = nh_r;
    chk_nxt  = chk_r;
    strb_nxt = 1'b0;
    pres_nxt = pres_r;
    cmd      = '0;
    case (st_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          nh_nxt   = num_hashes;
          chk_nxt  = (op == OP_CHECK);
          if (op == OP_CLEAR) begin
            cmd.clr_go = 1'b1;
            st_nxt = S_CLEAR;
          end else if (op == OP_ADD || op == OP_CHECK) begin
            if (num_hashes == '0) begin
              strb_nxt = (op == OP_CHECK);
              pres_nxt = 1'b1;
            end else begin
              st_nxt = S_HASH;
            end
          end
        end
      end
      S_HASH: begin
        cmd.hash_go = 1'b1;
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.idx_valid) begin
          if (chk_r) begin
            cmd.rd_bit = 1'b1;
            st_nxt = S_READ;
          end else begin
            cmd.set_bit = 1'b1;
            st_nxt = S_NEXT;
          end
        end
      end
      S_READ: begin
        if (!sts.bit_val) begin
          strb_nxt = 1'b1;
          pres_nxt = 1'b0;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.next = 1'b1;
        cnt_nxt  = cnt_r + NH_W'(1);
        if (cnt_r + NH_W'(1) == nh_r) begin
          strb_nxt = chk_r;
          pres_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_HASH;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      strb_r <= 1'b0;
      cnt_r  <= '0;
      nh_r   <= '0;
      chk_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      strb_r <= strb_nxt;
      cnt_r  <= cnt_nxt;
      nh_r   <= nh_nxt;
      chk_r  <= chk_nxt;
    end
    pres_r <= pres_nxt;
  end

  assign out_strobe        = strb_r;
  assign out_maybe_present = pres_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !accept) else $error("accept while busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strb_r |-> st_r == S_IDLE) else $error("result outside idle");
  a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.set_bit, cmd.rd_bit, cmd.clr_step})) else $error("memory port conflict");

endmodule

[hw/rtl/bloom_filter_membership.sv]
// Bloom filter over 64-bit keys with add, check and clear commands.
// After reset the block sweeps the filter store clear, one bit per cycle, so
// busy stays high until every bit is clear; a clear op holds busy through a
// second such sweep after its accept cycle. Each probe runs two 64-bit
// multiplies on a shared 32x32 multiplier, then a bit-serial remainder,
// then registers the index and touches the bit store. A check stops at the
// first clear bit it finds. A check's result shows on out_strobe for one
// cycle, right after the probe that decides it (or the accept, with zero
// probes), and cannot be stalled. cfg_ready is low while busy, so
// configuration only lands between items.
module bloom_filter_membership
  import bfm_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  in_op,
  input  logic [KEY_W-1:0] in_key,
  output logic             out_strobe,
  output logic             out_maybe_present,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [BC_W-1:0]  cfg_data
);

  logic [NH_W-1:0] nh_r;
  logic [BC_W-1:0] bc_r;
  bfm_cmd_t        cmd;
  bfm_sts_t        sts;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nh_r <= NH_RESET;
      bc_r <= BC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_NUM_HASHES) nh_r <= cfg_data[NH_W-1:0];
      else bc_r <= cfg_data;
    end
  end

  bfm_ctrl u_ctrl (
    .clk (clk), .rst_n (rst_n), .start (start), .op (in_op),
    .num_hashes (nh_r), .sts (sts), .cmd (cmd), .busy (busy),
    .out_strobe (out_strobe), .out_maybe_present (out_maybe_present)
  );

  bfm_datapath #(.FILTER_BITS(FILTER_BITS)) u_dp (
    .clk (clk), .rst_n (rst_n), .cmd (cmd), .key (in_key),
    .bit_count (bc_r), .sts (sts)
  );

endmodule

[verif/tb_bloom_filter_membership.sv]
// testbench for the bloom filter membership block: add, check and clear against a local model
`timescale 1ns / 1ps

module tb_bloom_filter_membership;
  import bfm_pkg::*;

  localparam int unsigned NBITS = FILTER_BITS_DEF;
  localparam longint unsigned LIMIT = 4000000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    bit               drain;  // hold this item until nothing is expected
  } bf_item_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [OP_W-1:0]  in_op;
  logic [KEY_W-1:0] in_key;
  logic             out_strobe;
  logic             out_maybe_present;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [BC_W-1:0]  cfg_data;

  bloom_filter_membership uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key(in_key),
    .out_strobe(out_strobe), .out_maybe_present(out_maybe_present),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // local copy of the filter and its settings
  bit              shadow_bits [NBITS];
  logic [NH_W-1:0] shadow_nh;
  logic [BC_W-1:0] shadow_bc;

  bf_item_t    pending_items[$];
  bit          presence_q[$];
  logic [63:0] added_keys[$];
  int          idle_pct;
  int          errors, n_items, n_checks, n_hits, cfg_writes;
  longint unsigned cycles;
  logic        took;

  function automatic logic [63:0] splitmix_fin(logic [63:0] v);
    v = v + GOLDEN;
    v = (v ^ (v >> 30)) * MIX1;
    v = (v ^ (v >> 27)) * MIX2;
    return v ^ (v >> 31);
  endfunction

  function automatic int unsigned bit_pos(logic [63:0] key, int unsigned i);
    logic [63:0] m;
    logic [63:0] pos;
    m = shadow_bc;
    if (m == 0) m = 1;
    if (m > NBITS) m = NBITS;
    pos = splitmix_fin(key + 64'(i) * STRIDE) % m;
    if (pos >= NBITS) pos = 0;
    return int'(pos);
  endfunction

  // updates the filter copy and queues the membership answer for checks
  task automatic apply_item(logic [OP_W-1:0] op, logic [63:0] key);
    bit hit;
    hit = 1'b1;
    case (op)
      OP_ADD: begin
        for (int unsigned i = 0; i < shadow_nh; i++) shadow_bits[bit_pos(key, i)] = 1'b1;
      end
      OP_CHECK: begin
        for (int unsigned i = 0; i < shadow_nh; i++)
          if (!shadow_bits[bit_pos(key, i)]) hit = 1'b0;
        presence_q.push_back(hit);
        n_checks++;
        if (hit) n_hits++;
      end
      OP_CLEAR: begin
        foreach (shadow_bits[j]) shadow_bits[j] = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // monitor, acceptance tracking and config capture
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      if (rst_n && out_strobe) begin
        if (presence_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          bit want;
          want = presence_q.pop_front();
          if (out_maybe_present !== want)
            report_mismatch($sformatf("maybe_present %b, expected %b", out_maybe_present, want));
        end
      end
      took <= rst_n && start && !busy;
      if (rst_n && start && !busy) begin
        apply_item(in_op, in_key);
        n_items++;
      end
      if (rst_n && cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_HASHES) shadow_nh = cfg_data[NH_W-1:0];
        else shadow_bc = cfg_data;
        cfg_writes <= cfg_writes + 1;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct &&
          !(pending_items[0].drain && presence_q.size() != 0)) begin
        bf_item_t it;
        it = pending_items.pop_front();
        in_op  <= it.op;
        in_key <= it.key;
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (pending_items.size() != 0 || start || presence_q.size() != 0);
    do @(negedge clk); while (busy);
    // an add or clear may still be running without a result to show it
    repeat (100) @(negedge clk);
    do @(negedge clk); while (busy);
  endtask

  task automatic write_reg(logic idx, logic [BC_W-1:0] val);
    int seen;
    wait_idle();
    seen = cfg_writes;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(logic [OP_W-1:0] op, logic [63:0] key, bit drain = 0);
    bf_item_t it;
    it.op = op;
    it.key = key;
    it.drain = drain;
    pending_items.push_back(it);
    if (op == OP_ADD) added_keys.push_back(key);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int nh_sel [5] = '{3, 8, 1, 5, 2};
    int bc_sel [5] = '{16384, 200, 8, 1000, 0};
    int idle_sel [5] = '{0, 79, 14, 79, 0};
    logic [63:0] k;
    int r;

    rst_n = 1'b0; start = 1'b0; in_op = OP_ADD; in_key = '0;
    cfg_valid = 1'b0; cfg_index = CFG_NUM_HASHES; cfg_data = '0;
    errors = 0; n_items = 0; n_checks = 0; n_hits = 0; cfg_writes = 0; cycles = 0;
    took = 1'b0; idle_pct = 0;
    foreach (shadow_bits[j]) shadow_bits[j] = 1'b0;
    shadow_nh = NH_RESET;
    shadow_bc = BC_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed, reset settings
    queue_item(OP_ADD, 64'h0);
    queue_item(OP_ADD, '1);
    queue_item(OP_CHECK, 64'h0);
    queue_item(OP_CHECK, '1);
    queue_item(OP_CHECK, 64'h8000_0000_0000_0001);
    queue_item(2'd3, 64'h0123_4567_89ab_cdef);  // unused op, ignored
    queue_item(OP_CHECK, '1);
    queue_item(OP_CLEAR, 64'h0);
    queue_item(OP_CHECK, 64'h0, 1);
    queue_item(OP_CHECK, '1);
    // zero probes: add does nothing, check always hits
    write_reg(CFG_NUM_HASHES, 15'd0);
    queue_item(OP_ADD, 64'h5555_5555_5555_5555);
    queue_item(OP_CHECK, 64'haaaa_aaaa_aaaa_aaaa);
    // most probes, bit count above the store saturates
    write_reg(CFG_NUM_HASHES, 15'h7fff);
    write_reg(CFG_BIT_COUNT, 15'h7fff);
    queue_item(OP_ADD, 64'hdead_beef_cafe_f00d);
    queue_item(OP_CHECK, 64'hdead_beef_cafe_f00d);
    queue_item(OP_CHECK, 64'hdead_beef_cafe_f00e);
    // zero bit count behaves as one bit
    write_reg(CFG_NUM_HASHES, 15'd2);
    write_reg(CFG_BIT_COUNT, 15'd0);
    queue_item(OP_CHECK, 64'h1234);
    queue_item(OP_ADD, 64'h1234);
    queue_item(OP_CHECK, 64'h9876_5432_1000_0000);
    write_reg(CFG_BIT_COUNT, 15'd1);
    queue_item(OP_CHECK, 64'h0);
    queue_item(OP_CLEAR, '1);
    queue_item(OP_CHECK, 64'h1234);

    // random phases; checks reuse an added key about half the time so hits occur
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_NUM_HASHES, 15'(nh_sel[p]));
      write_reg(CFG_BIT_COUNT, 15'(bc_sel[p] == 0 ? $urandom_range(32767) : bc_sel[p]));
      idle_pct = idle_sel[p];
      added_keys.delete();
      for (int n = 0; n < 125; n++) begin
        r = $urandom_range(99);
        if (r < 2) begin
          queue_item(OP_CLEAR, rand_key());
        end else if (r < 5) begin
          queue_item(2'd3, rand_key());
        end else if (r < 45) begin
          queue_item(OP_ADD, rand_key());
        end else begin
          if (added_keys.size() != 0 && $urandom_range(1))
            k = added_keys[$urandom_range(added_keys.size() - 1)];
          else
            k = rand_key();
          queue_item(OP_CHECK, k, n == 60);
        end
      end
    end

    wait_idle();
    $display("ran %0d items with %0d checks (%0d hits), %0d register writes",
             n_items, n_checks, n_hits, cfg_writes);
    $display("covered zero and max probes, bit count saturation, clears and unused op");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/bfm_pkg.sv
hw/rtl/bfm_mul64.sv
hw/rtl/bfm_mod.sv
hw/rtl/bfm_datapath.sv
hw/rtl/bfm_ctrl.sv
hw/rtl/bloom_filter_membership.sv
verif/tb_bloom_filter_membership.sv
